// ----- src/ps2mct_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared widths, register indexes, reset values and packet byte masks.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mct_pkg;

  // Default coordinate width of the cursor position
  localparam int unsigned COORD_BITS_DEF = 12;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
  localparam logic                  WHEEL_MODE_RST    = 1'b0;

  // Byte positions within a packet
  localparam logic [1:0] BYTE_STATUS = 2'd0;
  localparam logic [1:0] BYTE_DY     = 2'd2;
  localparam logic [1:0] BYTE_WHEEL  = 2'd3;

  // First byte of a packet: sync bit, overflow bits, sign bits, buttons
  localparam logic [7:0] SYNC_MASK     = 8'h08;
  localparam logic [7:0] OVERFLOW_MASK = 8'hC0;
  localparam int unsigned X_SIGN_BIT   = 4;
  localparam int unsigned Y_SIGN_BIT   = 5;
  localparam int unsigned LEFT_BIT     = 0;
  localparam int unsigned RIGHT_BIT    = 1;
  localparam int unsigned MIDDLE_BIT   = 2;

endpackage : ps2mct_pkg

`default_nettype wire

// ----- src/ps2mct_ifs.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker channel interfaces
// Received byte channel and cursor result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2mct_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : ps2mct_rx_if

interface ps2mct_pos_if #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_button;
  logic                  right_button;
  logic                  middle_button;
  logic signed [7:0]     wheel_delta;

  modport source (output valid, output cursor_x, output cursor_y, output left_button,
                  output right_button, output middle_button, output wheel_delta,
                  input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_button,
                  input right_button, input middle_button, input wheel_delta,
                  output ready);
endinterface : ps2mct_pos_if

`default_nettype wire

// ----- src/ps2_mouse_packet_cursor_tracker_top.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Frames received mouse bytes into 3- or 4-byte packets, decodes the deltas
// and buttons, and tracks a cursor clamped to the configured screen.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transaction   Payload
//  rx       in   one byte      rx_byte
//  res      out  one packet    cursor_x, cursor_y, buttons, wheel_delta
//  cfg      in   reg write     cfg_we, cfg_index, cfg_wdata
//
//  One byte is accepted per cycle unless rx is stalled; a completing byte is
//  decoded, moved and clamped in the same cycle and its result is registered
//  in the output register. The output register is the only buffer: rx
//  stalls only while a result is held and res.ready is low. Synchronous reset
//  clears the framing position, the cursor, the centred flag and the
//  registers to their defaults; no clearing pass is needed.
//
`default_nettype none

module ps2_mouse_packet_cursor_tracker_top #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ps2mct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  ps2mct_rx_if.sink                                rx,
  ps2mct_pos_if.source                             res
);

  localparam int unsigned RegW = ps2mct_pkg::CFG_DATA_W;
  localparam int unsigned CmpW = (COORD_BITS + 1 > RegW) ? COORD_BITS + 1 : RegW;
  localparam int unsigned SumW = COORD_BITS + 3;

  // Configuration registers
  logic [RegW-1:0] screen_width;
  logic [RegW-1:0] screen_height;
  logic            wheel_mode;

  // Framing and cursor state
  logic [1:0]            byte_position;
  logic [1:0]            byte_position_next;
  logic [7:0]            packet_bytes [3];
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  centred;

  // Result register
  logic                  out_valid;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [2:0]            out_buttons;
  logic signed [7:0]     out_wheel;

  logic       accept;
  logic       drop;
  logic       last_byte;
  logic       complete;
  logic [7:0] b;
  logic [7:0] b0;
  logic [7:0] b2;

  logic [COORD_BITS:0]       eff_w;
  logic [COORD_BITS:0]       eff_h;
  logic signed [8:0]         dx;
  logic signed [8:0]         dy;
  logic signed [7:0]         dz;
  logic signed [SumW-1:0]    base_x;
  logic signed [SumW-1:0]    base_y;
  logic signed [SumW-1:0]    sum_x;
  logic signed [SumW-1:0]    sum_y;
  logic signed [SumW-1:0]    max_x;
  logic signed [SumW-1:0]    max_y;
  logic [COORD_BITS-1:0]     new_x;
  logic [COORD_BITS-1:0]     new_y;

  // Map a size register onto 1 .. 2^COORD_BITS
  function automatic logic [COORD_BITS:0] eff_size(input logic [RegW-1:0] r);
    logic [CmpW-1:0] ext;
    logic [CmpW-1:0] lim;
    ext = CmpW'(r);
    lim = CmpW'(1) << COORD_BITS;
    if (ext == '0) begin
      return (COORD_BITS + 1)'(1);
    end else if (ext > lim) begin
      return (COORD_BITS + 1)'(lim);
    end else begin
      return (COORD_BITS + 1)'(ext);
    end
  endfunction

  // Handshake: the output register can take a new result when empty or draining
  assign rx.ready = !out_valid || res.ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // Framing: drop status bytes without the sync bit or with an overflow bit, detect the closing byte
  always_comb begin
    drop = (byte_position == ps2mct_pkg::BYTE_STATUS) &&
           (((b & ps2mct_pkg::SYNC_MASK) == 8'h00) ||
            ((b & ps2mct_pkg::OVERFLOW_MASK) != 8'h00));
    last_byte = (byte_position == ps2mct_pkg::BYTE_WHEEL) ||
                ((byte_position == ps2mct_pkg::BYTE_DY) && !wheel_mode);
    complete  = accept && !drop && last_byte;
    if (accept && !drop) begin
      byte_position_next = last_byte ? ps2mct_pkg::BYTE_STATUS : byte_position + 2'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  // Decode deltas; the Y byte bypasses the store when it closes the packet
  always_comb begin
    b0 = packet_bytes[0];
    b2 = (byte_position == ps2mct_pkg::BYTE_DY) ? b : packet_bytes[2];
    dx = {b0[ps2mct_pkg::X_SIGN_BIT], packet_bytes[1]};
    dy = {b0[ps2mct_pkg::Y_SIGN_BIT], b2};
    dz = (wheel_mode && (byte_position == ps2mct_pkg::BYTE_WHEEL)) ? b : 8'sd0;
  end

  // Move and clamp the cursor
  always_comb begin
    eff_w  = eff_size(screen_width);
    eff_h  = eff_size(screen_height);
    base_x = centred ? SumW'(pos_x) : SumW'(eff_w >> 1);
    base_y = centred ? SumW'(pos_y) : SumW'(eff_h >> 1);
    max_x  = SumW'(eff_w) - SumW'(1);
    max_y  = SumW'(eff_h) - SumW'(1);
    sum_x  = base_x + SumW'(dx);
    sum_y  = base_y - SumW'(dy);

    if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x > max_x) begin
      new_x = max_x[COORD_BITS-1:0];
    end else begin
      new_x = sum_x[COORD_BITS-1:0];
    end

    if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y > max_y) begin
      new_y = max_y[COORD_BITS-1:0];
    end else begin
      new_y = sum_y[COORD_BITS-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mct_pkg::SCREEN_WIDTH_RST;
      screen_height <= ps2mct_pkg::SCREEN_HEIGHT_RST;
      wheel_mode    <= ps2mct_pkg::WHEEL_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mct_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        ps2mct_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        ps2mct_pkg::CFG_WHEEL_MODE:    wheel_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Hold packet bytes as they arrive
  always_ff @(posedge clk) begin
    if (accept && !drop && (byte_position != ps2mct_pkg::BYTE_WHEEL)) begin
      packet_bytes[byte_position] <= b;
    end
  end

  // Advance framing and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= ps2mct_pkg::BYTE_STATUS;
      pos_x         <= '0;
      pos_y         <= '0;
      centred       <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      if (complete) begin
        pos_x   <= new_x;
        pos_y   <= new_y;
        centred <= 1'b1;
      end
    end
  end

  // Result register: load on a closing byte, clear once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (complete) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      out_x       <= new_x;
      out_y       <= new_y;
      out_buttons <= {b0[ps2mct_pkg::MIDDLE_BIT], b0[ps2mct_pkg::RIGHT_BIT],
                      b0[ps2mct_pkg::LEFT_BIT]};
      out_wheel   <= dz;
    end
  end

  assign res.valid         = out_valid;
  assign res.cursor_x      = out_x;
  assign res.cursor_y      = out_y;
  assign res.left_button   = out_buttons[0];
  assign res.right_button  = out_buttons[1];
  assign res.middle_button = out_buttons[2];
  assign res.wheel_delta   = out_wheel;

endmodule : ps2_mouse_packet_cursor_tracker_top

`default_nettype wire
